// ----- design/pwic_pkg.sv -----
// Shared widths, register codes and stage payload types of the PID controller.
package pwic_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned LIMIT_W   = 20;
  localparam int unsigned ERR_W     = DATA_W + 1;
  localparam int unsigned INTEG_W   = LIMIT_W + 1;
  localparam int unsigned DERIV_W   = ERR_W + 1;
  localparam int unsigned PROD_P_W  = GAIN_W + ERR_W;
  localparam int unsigned PROD_I_W  = GAIN_W + INTEG_W;
  localparam int unsigned PROD_D_W  = GAIN_W + DERIV_W;
  localparam int unsigned SUM_W     = PROD_I_W + 2;
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DRIVE_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 20;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P = 3'd0,
    CFG_GAIN_I = 3'd1,
    CFG_GAIN_D = 3'd2,
    CFG_LIMIT  = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
  } gains_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERIV_W-1:0] deriv;
  } terms_t;

  typedef struct packed {
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_I_W-1:0] prod_i;
    logic signed [PROD_D_W-1:0] prod_d;
  } prods_t;

endpackage

// ----- design/pwic_terms.sv -----
// Error, clamped integral and derivative stage; holds the controller state.
module pwic_terms (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  up_valid,
  output logic                                  up_stall,
  input  logic signed [pwic_pkg::DATA_W-1:0]    setpoint,
  input  logic signed [pwic_pkg::DATA_W-1:0]    measured_value,
  input  logic [pwic_pkg::LIMIT_W-1:0]          integral_limit,
  output logic                                  dn_valid,
  input  logic                                  dn_stall,
  output pwic_pkg::terms_t                      dn_terms
);

  localparam int unsigned ACC_W = pwic_pkg::INTEG_W + 1;

  logic                                  valid_r;
  pwic_pkg::terms_t                      terms_r;
  pwic_pkg::terms_t                      terms_nxt;
  logic signed [pwic_pkg::INTEG_W-1:0]   integ_r;
  logic signed [pwic_pkg::ERR_W-1:0]     prev_err_r;
  logic signed [ACC_W-1:0]               acc;
  logic signed [ACC_W-1:0]               lim_pos;
  logic signed [ACC_W-1:0]               lim_neg;
  logic                                  hold;
  logic                                  load;

  assign hold     = valid_r && dn_stall;
  assign load     = up_valid && !hold;
  assign up_stall = hold;

  always_comb begin
    terms_nxt.err = pwic_pkg::ERR_W'(setpoint) - pwic_pkg::ERR_W'(measured_value);
    acc     = ACC_W'(integ_r) + ACC_W'(terms_nxt.err);
    lim_pos = $signed({{(ACC_W - pwic_pkg::LIMIT_W){1'b0}}, integral_limit});
    lim_neg = -lim_pos;
    // The sum is formed at full width first, so only the clamp limits it.
    if (acc > lim_pos) begin
      terms_nxt.integ = pwic_pkg::INTEG_W'(lim_pos);
    end else if (acc < lim_neg) begin
      terms_nxt.integ = pwic_pkg::INTEG_W'(lim_neg);
    end else begin
      terms_nxt.integ = pwic_pkg::INTEG_W'(acc);
    end
    terms_nxt.deriv = pwic_pkg::DERIV_W'(terms_nxt.err) - pwic_pkg::DERIV_W'(prev_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      integ_r    <= '0;
      prev_err_r <= '0;
    end else begin
      if (!hold) begin
        valid_r <= up_valid;
      end
      if (load) begin
        integ_r    <= terms_nxt.integ;
        prev_err_r <= terms_nxt.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      terms_r <= terms_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_terms = terms_r;

  a_integ_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(load)) |->
      (integ_r <= $signed({1'b0, $past(integral_limit)})) &&
      (integ_r >= -$signed({1'b0, $past(integral_limit)})))
    else $error("integral left its clamp range");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(load)) |-> ($stable(integ_r) && $stable(prev_err_r)))
    else $error("controller state changed without a transfer");

  a_prev_err_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(load)) |-> (prev_err_r == terms_r.err))
    else $error("previous error does not match the registered error");

endmodule

// ----- design/pwic_mul.sv -----
// Gain multiply stage: three signed products, registered.
module pwic_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  pwic_pkg::gains_t  gains,
  input  logic              up_valid,
  output logic              up_stall,
  input  pwic_pkg::terms_t  up_terms,
  output logic              dn_valid,
  input  logic              dn_stall,
  output pwic_pkg::prods_t  dn_prods
);

  logic              valid_r;
  pwic_pkg::prods_t  prods_r;
  pwic_pkg::prods_t  prods_nxt;
  logic              hold;

  assign hold     = valid_r && dn_stall;
  assign up_stall = hold;

  always_comb begin
    prods_nxt.prod_p = pwic_pkg::PROD_P_W'(gains.gain_p) * pwic_pkg::PROD_P_W'(up_terms.err);
    prods_nxt.prod_i = pwic_pkg::PROD_I_W'(gains.gain_i) * pwic_pkg::PROD_I_W'(up_terms.integ);
    prods_nxt.prod_d = pwic_pkg::PROD_D_W'(gains.gain_d) * pwic_pkg::PROD_D_W'(up_terms.deriv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!hold) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !hold) begin
      prods_r <= prods_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_prods = prods_r;

endmodule

// ----- design/pwic_out.sv -----
// Output stage: sum of products, floor shift by the gain fraction, saturation.
module pwic_out (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_stall,
  input  pwic_pkg::prods_t                    up_prods,
  output logic                                dn_valid,
  input  logic                                dn_stall,
  output logic signed [pwic_pkg::DRIVE_W-1:0] drive_value
);

  localparam int unsigned SHIFT_W = pwic_pkg::SUM_W - pwic_pkg::FRAC_BITS;
  localparam int unsigned WIDE_W  = (SHIFT_W > pwic_pkg::DRIVE_W) ? SHIFT_W
                                                                 : pwic_pkg::DRIVE_W + 1;

  logic                                valid_r;
  logic signed [pwic_pkg::DRIVE_W-1:0] drive_r;
  logic signed [pwic_pkg::DRIVE_W-1:0] drive_nxt;
  logic signed [pwic_pkg::SUM_W-1:0]   sum;
  logic signed [WIDE_W-1:0]            shifted;
  logic signed [WIDE_W-1:0]            max_val;
  logic signed [WIDE_W-1:0]            min_val;
  logic                                hold;

  assign hold     = valid_r && dn_stall;
  assign up_stall = hold;

  always_comb begin
    sum = pwic_pkg::SUM_W'(up_prods.prod_p) + pwic_pkg::SUM_W'(up_prods.prod_i)
        + pwic_pkg::SUM_W'(up_prods.prod_d);
    // Dropping the fraction bits of a two's complement value rounds toward minus infinity.
    shifted = WIDE_W'($signed(sum[pwic_pkg::SUM_W-1:pwic_pkg::FRAC_BITS]));
    max_val = $signed({{(WIDE_W - pwic_pkg::DRIVE_W + 1){1'b0}},
                       {(pwic_pkg::DRIVE_W - 1){1'b1}}});
    min_val = ~max_val;
    if (shifted > max_val) begin
      drive_nxt = pwic_pkg::DRIVE_W'(max_val);
    end else if (shifted < min_val) begin
      drive_nxt = pwic_pkg::DRIVE_W'(min_val);
    end else begin
      drive_nxt = pwic_pkg::DRIVE_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!hold) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !hold) begin
      drive_r <= drive_nxt;
    end
  end

  assign dn_valid    = valid_r;
  assign drive_value = drive_r;

endmodule

// ----- design/pid_with_integral_clamp.sv -----
// Top level of the positional PID controller with a clamped integral.
//
// Use: each transfer on the input channel (in_valid high, in_stall low) brings a
// setpoint and a measured value. The block forms the error, adds it to the
// integral, clamps the integral to plus or minus cfg register integral_limit,
// takes the derivative against the previous error and returns one drive value,
// (kp*e + ki*i + kd*d) >> 8 with floor rounding, saturated to 32 bits.
// Pipeline: a result passes the terms, product and output registers in turn and
// sits in the output register until the receiver takes it.
// Throughput: one item per cycle unless stalled. The only loop is the integral
// and previous error update in the first stage, a single add and clamp, so
// nothing else bounds the rate; multiplies and final sum have their own stages.
// Stalls: each of the three stages holds only when it is full and the stage
// after it holds, so bubbles are filled while out_stall is high; in_stall
// rises only when the whole pipeline is full and the output is stalled.
// Configuration: cfg_ready is always high; write gains and the limit only
// while no item is in flight. Unknown register indexes are ignored.
// Reset (synchronous, rst_n low): the pipeline empties, the integral and the
// previous error go to zero, gains to zero and the limit to 5000.
module pid_with_integral_clamp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [pwic_pkg::DATA_W-1:0]      in_setpoint,
  input  logic signed [pwic_pkg::DATA_W-1:0]      in_measured_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [pwic_pkg::DRIVE_W-1:0]     out_drive_value,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [pwic_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pwic_pkg::CFG_DAT_W-1:0]          cfg_data
);

  pwic_pkg::gains_t              gains_r;
  logic [pwic_pkg::LIMIT_W-1:0]  limit_r;

  logic                          t_valid;
  logic                          t_stall;
  pwic_pkg::terms_t              t_terms;
  logic                          m_valid;
  logic                          m_stall;
  pwic_pkg::prods_t              m_prods;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
      limit_r <= pwic_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pwic_pkg::cfg_idx_t'(cfg_index))
        pwic_pkg::CFG_GAIN_P: gains_r.gain_p <= cfg_data[pwic_pkg::GAIN_W-1:0];
        pwic_pkg::CFG_GAIN_I: gains_r.gain_i <= cfg_data[pwic_pkg::GAIN_W-1:0];
        pwic_pkg::CFG_GAIN_D: gains_r.gain_d <= cfg_data[pwic_pkg::GAIN_W-1:0];
        pwic_pkg::CFG_LIMIT:  limit_r        <= cfg_data[pwic_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage one: error, clamped integral and derivative; owns the state.
  pwic_terms u_terms (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (in_valid),
    .up_stall       (in_stall),
    .setpoint       (in_setpoint),
    .measured_value (in_measured_value),
    .integral_limit (limit_r),
    .dn_valid       (t_valid),
    .dn_stall       (t_stall),
    .dn_terms       (t_terms)
  );

  // Stage two: the three gain products.
  pwic_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .gains    (gains_r),
    .up_valid (t_valid),
    .up_stall (t_stall),
    .up_terms (t_terms),
    .dn_valid (m_valid),
    .dn_stall (m_stall),
    .dn_prods (m_prods)
  );

  // Stage three: sum, shift and saturate into the output register.
  pwic_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (m_valid),
    .up_stall    (m_stall),
    .up_prods    (m_prods),
    .dn_valid    (out_valid),
    .dn_stall    (out_stall),
    .drive_value (out_drive_value)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (t_valid && m_valid && out_valid && out_stall))
    else $error("input stalled while the pipeline had room");

  a_no_stall_free_output: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_stall && !m_valid) |=> !out_valid)
    else $error("output produced a result with no item in the stage before it");

endmodule

// ----- tb/pid_drive_checker.sv -----
// Checker that predicts and compares the drive values of the PID controller.
module pid_drive_checker
  import pwic_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [DATA_W-1:0]   in_setpoint,
  input  logic signed [DATA_W-1:0]   in_measured_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [DRIVE_W-1:0]  out_drive_value,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DAT_W-1:0]       cfg_data,
  output int                         outstanding,
  output int                         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint DRIVE_MAX = (longint'(1) <<< (DRIVE_W - 1)) - 1;
  localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

  logic signed [GAIN_W-1:0]  gain_p_q;
  logic signed [GAIN_W-1:0]  gain_i_q;
  logic signed [GAIN_W-1:0]  gain_d_q;
  logic [LIMIT_W-1:0]        limit_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [ERR_W-1:0]   prev_err_q;

  logic signed [DRIVE_W-1:0] expected_drive[$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    case (cfg_idx_t'(idx))
      CFG_GAIN_P: gain_p_q = data[GAIN_W-1:0];
      CFG_GAIN_I: gain_i_q = data[GAIN_W-1:0];
      CFG_GAIN_D: gain_d_q = data[GAIN_W-1:0];
      CFG_LIMIT:  limit_q  = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // One controller step: updates the integral and the previous error and
  // returns the drive value that this step must produce.
  function automatic logic signed [DRIVE_W-1:0] advance_pid(
      input logic signed [DATA_W-1:0] sp,
      input logic signed [DATA_W-1:0] mv);
    longint err, acc, lim, deriv, weighted, shifted;
    err = longint'(sp) - longint'(mv);
    acc = longint'(integ_q) + err;
    lim = longint'(limit_q);
    if (acc > lim) begin
      acc = lim;
    end else if (acc < -lim) begin
      acc = -lim;
    end
    integ_q = INTEG_W'(acc);
    deriv = err - longint'(prev_err_q);
    weighted = longint'(gain_p_q) * err + longint'(gain_i_q) * acc
             + longint'(gain_d_q) * deriv;
    shifted = weighted >>> FRAC_BITS;
    if (shifted > DRIVE_MAX) begin
      shifted = DRIVE_MAX;
    end else if (shifted < DRIVE_MIN) begin
      shifted = DRIVE_MIN;
    end
    prev_err_q = ERR_W'(err);
    return DRIVE_W'(shifted);
  endfunction

  always @(posedge clk) begin
    logic signed [DRIVE_W-1:0] want;
    if (!rst_n) begin
      gain_p_q   = '0;
      gain_i_q   = '0;
      gain_d_q   = '0;
      limit_q    = LIMIT_RESET;
      integ_q    = '0;
      prev_err_q = '0;
      expected_drive.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      // Results are checked before this edge's input is predicted, since a
      // result can never belong to an input taken at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_drive.size() == 0) begin
          report_mismatch($sformatf("drive_value %0d with no transfer waiting",
                                    out_drive_value));
        end else begin
          want = expected_drive.pop_front();
          if (out_drive_value !== want) begin
            report_mismatch($sformatf("drive_value got %0d, want %0d",
                                      out_drive_value, want));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
      end
      if (in_valid && !in_stall) begin
        expected_drive.push_back(advance_pid(in_setpoint, in_measured_value));
      end
      outstanding <= expected_drive.size();
    end
  end

endmodule

// ----- tb/pid_with_integral_clamp_tb.sv -----
// Top of the PID controller testbench: clock, reset, stimulus, watchdog and verdict.
module pid_with_integral_clamp_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwic_pkg::*;

  // The drain pause lets the pipeline settle after the last result, before
  // registers are rewritten or the run ends.
  localparam int DRAIN_CYCLES  = 8;
  // The slowest correct run stalls the output at random with recv_stall_pct at 76,
  // so a stretch of this many cycles without any transfer means a hang.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BLOCK_ITEMS    = 50;
  localparam int BLOCKS         = 4;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [DATA_W-1:0]   in_setpoint = '0;
  logic signed [DATA_W-1:0]   in_measured_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [DRIVE_W-1:0]  out_drive_value;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DAT_W-1:0]       cfg_data = '0;

  int outstanding;
  int fail_count;
  int send_idle_pct = 22;
  int recv_stall_pct = 76;
  int quiet_cycles = 0;

  pid_with_integral_clamp dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_setpoint       (in_setpoint),
    .in_measured_value (in_measured_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_value   (out_drive_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  pid_drive_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_setpoint       (in_setpoint),
    .in_measured_value (in_measured_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_value   (out_drive_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .outstanding       (outstanding),
    .fail_count        (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver decides afresh every cycle whether to hold off the output.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // The watchdog counts cycles in which no channel moves a transfer. Reset
  // cycles do not count.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one item and holds it until the block takes it. Before the item
  // the sender may idle for some cycles, drawn per cycle from send_idle_pct.
  task automatic send_item(input logic signed [DATA_W-1:0] sp,
                           input logic signed [DATA_W-1:0] mv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_setpoint       <= sp;
    in_measured_value <= mv;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops sending and waits until every predicted drive value has arrived,
  // then lets the pipeline settle. The first edge lets the checker count the
  // last transfer before its outstanding count is trusted.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write. The valid stays high across back-to-back writes;
  // the caller lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Rewrites every register while the block is idle. The gain writes carry
  // random bits above the 16-bit gain, which the block must drop, and a write
  // to an index past the last register must change nothing.
  task automatic configure(input logic signed [GAIN_W-1:0] gp,
                           input logic signed [GAIN_W-1:0] gi,
                           input logic signed [GAIN_W-1:0] gd,
                           input logic [LIMIT_W-1:0] lim);
    logic [CFG_IDX_W-1:0] spare_idx;
    drain_pipeline();
    spare_idx = CFG_IDX_W'(int'(CFG_LIMIT) + 1 + $urandom_range(3));
    write_reg(CFG_GAIN_P, {4'($urandom), gp});
    write_reg(CFG_GAIN_I, {4'($urandom), gi});
    write_reg(CFG_GAIN_D, {4'($urandom), gd});
    write_reg(CFG_LIMIT, lim);
    write_reg(spare_idx, CFG_DAT_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [GAIN_W-1:0] random_gain();
    case ($urandom_range(3))
      0: return GAIN_W'($urandom);
      1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      2: return GAIN_W'($urandom_range(1024)) - 16'sd512;
      default: return $urandom_range(1) ? 16'sd0 : 16'sd256;
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] random_limit();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return LIMIT_W'($urandom);
      default: return LIMIT_W'($urandom_range(2000));
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] corner_value();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return -16'sd1;
      4: return 16'sd1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [DATA_W-1:0] track_sp;
    logic signed [DATA_W-1:0] track_mv;
    int kind;

    // Reset is held once, at the start of the run.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Gains come out of reset at zero, so the extremes of the
    // error give a zero drive while the integral clamps at the reset limit.
    send_item(16'sh7FFF, 16'sh8000);
    send_item(16'sh8000, 16'sh7FFF);

    // Extreme gains with the widest limit: the integral grows without clamping
    // and the derivative swings across its full range.
    configure(16'sh7FFF, 16'sh8000, 16'sh7FFF, '1);
    repeat (3) send_item(16'sh7FFF, 16'sh8000);
    repeat (2) send_item(16'sh8000, 16'sh7FFF);
    send_item(16'sd0, 16'sd0);
    send_item(-16'sd1, 16'sd0);
    send_item(16'sd0, 16'sd1);

    // Tiny gains and a tiny limit show floor rounding of the final shift on
    // small negative sums, and the clamp acting on the integral.
    configure(16'sd1, -16'sd1, 16'sd3, 20'd7);
    send_item(-16'sd1, 16'sd0);
    send_item(16'sd0, 16'sd1);
    send_item(16'sd5, -16'sd3);
    send_item(16'sd2, 16'sd2);

    // A zero limit holds the integral at zero whatever the error.
    configure(16'sh8000, 16'sh7FFF, 16'sh8000, '0);
    send_item(16'sh7FFF, 16'sh8000);
    send_item(16'sh8000, 16'sh7FFF);
    send_item(16'sh7FFF, 16'sh7FFF);

    // Build a large integral, then lower the limit beneath it: the next
    // step must clamp to the new bound.
    configure(16'sd0, 16'sd256, 16'sd0, '1);
    repeat (4) send_item(16'sh7FFF, 16'sh8000);
    configure(16'sd0, 16'sd256, 16'sd0, 20'd1000);
    send_item(16'sd0, 16'sd0);
    send_item(16'sh8000, 16'sh7FFF);

    // Random part in three idling phases: sender light and receiver heavy,
    // then the reverse, then no idling at all. Each phase runs several
    // register settings.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 22;
          recv_stall_pct = 76;
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 22;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        configure(random_gain(), random_gain(), random_gain(), random_limit());
        track_sp = DATA_W'($urandom);
        track_mv = track_sp + DATA_W'($urandom_range(512)) - 16'sd256;
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          kind = $urandom_range(9);
          if (kind < 4) begin
            send_item(DATA_W'($urandom), DATA_W'($urandom));
          end else if (kind < 6) begin
            send_item(corner_value(), corner_value());
          end else begin
            // A tracking loop: a steady setpoint and a measurement that
            // drifts near it, so the integral winds toward the clamp.
            track_mv = track_mv + DATA_W'($urandom_range(32)) - 16'sd16;
            send_item(track_sp, track_mv);
          end
          // Now and then the sender holds off until the pipeline is empty.
          if ($urandom_range(79) == 0) begin
            drain_pipeline();
          end
        end
      end
    end

    drain_pipeline();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- pid_with_integral_clamp.f -----
design/pwic_pkg.sv
design/pwic_terms.sv
design/pwic_mul.sv
design/pwic_out.sv
design/pid_with_integral_clamp.sv
tb/pid_drive_checker.sv
tb/pid_with_integral_clamp_tb.sv
